>>> rtl/core/yp2rgb_pkg.sv
// Package for the YUV pair to RGB555 core: constants, types and helpers.
package yp2rgb_pkg;

  // Field widths
  localparam int unsigned SampleW  = 8;
  localparam int unsigned PixelW   = 15;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned Lanes    = 2;

  // Conversion coefficients
  localparam int unsigned ChromaMid = 128;
  localparam int unsigned CoefU     = 475;
  localparam int unsigned CoefV     = 403;
  localparam int unsigned CoefYG    = 51;
  localparam int unsigned CoefRG    = 38;
  localparam int unsigned CoefBG    = 13;

  // Chroma offset, floor((c - 128) * k / 256), range -238..235
  typedef logic signed [8:0] chroma_off_t;
  // Pre-clip channel sum, range -238..490
  typedef logic signed [9:0] chan_sum_t;
  typedef logic [SampleW-1:0] sample_t;
  typedef logic [PixelW-1:0]  pixel_t;

  // Limit a signed sum to 0..255
  function automatic sample_t clip8(input chan_sum_t v);
    sample_t res;
    if (v < 0) begin
      res = '0;
    end else if (v > 10'sd255) begin
      res = '1;
    end else begin
      res = v[SampleW-1:0];
    end
    return res;
  endfunction

  // Chroma offset from an unsigned sample and coefficient
  function automatic chroma_off_t chroma_offset(input sample_t c, input logic [8:0] k);
    logic signed [9:0]  centred;
    logic signed [19:0] prod;
    centred = $signed({2'b00, c}) - 10'sd128;
    prod    = 20'(centred) * $signed({11'b0, k});
    // arithmetic shift by 8: the floored quotient fits in bits 16:8
    return prod[16:8];
  endfunction

endpackage

>>> rtl/core/yuv_pair_to_rgb555_core.sv
// Three-stage pipeline: chroma offsets, red/blue clip, green and packing.
// With no stall, an accepted item passes the stage 1, 2 and 3 registers in turn,
// and m_axis_tvalid_o rises when it is written into the stage 3 register.
// Throughput: one pixel pair per cycle while the output is taken; each stage moves on when the next is
// free or moving, so a held output stalls the pipe without loss or repeat.
// Reset (rst_ni low, asynchronous) empties all stage valid bits; data is kept.
module yuv_pair_to_rgb555_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // luma_first[7:0], luma_second[15:8], chroma_blue[23:16], chroma_red[31:24]
  input  logic [yp2rgb_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // pixel_first[14:0], pixel_second[29:15], zero [31:30]
  output logic [yp2rgb_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i
);
  import yp2rgb_pkg::*;

  // Stage enables, back to front
  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  assign en3 = !v3_q || m_axis_tready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  // Stage 1: chroma offsets
  sample_t     y1_q [Lanes];
  chroma_off_t du_q, dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid_i) begin
      y1_q[0] <= s_axis_tdata_i[7:0];
      y1_q[1] <= s_axis_tdata_i[15:8];
      du_q    <= chroma_offset(s_axis_tdata_i[23:16], 9'(CoefU));
      dv_q    <= chroma_offset(s_axis_tdata_i[31:24], 9'(CoefV));
    end
  end

  // Stage 2: clipped red and blue, luma term for green
  sample_t    r2_d [Lanes], b2_d [Lanes], r2_q [Lanes], b2_q [Lanes];
  logic [8:0] yt2_d [Lanes], yt2_q [Lanes];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      logic [13:0] yprod;
      yprod    = 14'(y1_q[i]) * 14'(CoefYG);
      r2_d[i]  = clip8($signed({2'b00, y1_q[i]}) + {dv_q[8], dv_q});
      b2_d[i]  = clip8($signed({2'b00, y1_q[i]}) + {du_q[8], du_q});
      yt2_d[i] = 9'(y1_q[i]) + 9'(yprod[13:7]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      r2_q  <= r2_d;
      b2_q  <= b2_d;
      yt2_q <= yt2_d;
    end
  end

  // Stage 3: green from clipped red and blue, then pack
  pixel_t pix_d [Lanes], pix_q [Lanes];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      logic [13:0] csum;
      sample_t     g;
      csum = 14'(r2_q[i]) * 14'(CoefRG) + 14'(b2_q[i]) * 14'(CoefBG);
      g    = clip8($signed({1'b0, yt2_q[i]}) - $signed({3'b000, csum[13:7]}));
      pix_d[i] = {r2_q[i][7:3], g[7:3], b2_q[i][7:3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      pix_q <= pix_d;
    end
  end

  // Output item
  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {2'b00, pix_q[1], pix_q[0]};

endmodule

>>> rtl/core/yp2rgb_checker.sv
// Port checker for the YUV pair to RGB555 core, bound into yuv_pair_to_rgb555_core.
module yp2rgb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic [yp2rgb_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [yp2rgb_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i
);
  import yp2rgb_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // A stalled output item stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  // A stalled output item keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed while stalled");

  // With the sink ready the pipe never pushes back
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled with sink ready");

  // An accepted item reaches the output if the sink stays ready while it moves through the pipe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc ##1 m_axis_tready_i ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("item not delivered at expected latency");

  // Padding bits above the second pixel are zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OutDataW-1:2*PixelW] == '0)
    else $error("padding bits set");

endmodule

bind yuv_pair_to_rgb555_core yp2rgb_checker u_yp2rgb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

>>> tb/tb_top.sv
// Self-checking testbench for the YUV pair to RGB555 streaming core.
module tb_top;
  import yp2rgb_pkg::*;

  localparam int unsigned QuietLimit = 4000;   // cycles with no item moving
  localparam int unsigned PipeDepth  = 3;
  localparam int unsigned PhaseItems = 335;

  // Expected pixel pair as it sits in m_axis_tdata, first pixel lowest
  typedef struct packed {
    logic [OutDataW-1:2*PixelW-1+1] pad;
    pixel_t                         second;
    pixel_t                         first;
  } pixel_pair_t;

  // Predicts each converted pair and checks results in arrival order
  class pair_scoreboard;
    pixel_pair_t pair_q[$];
    int unsigned errors;

    // floor((c - 128) * k / 256), arithmetic shift on a signed product
    function int chroma_shift(sample_t c, int k);
      int prod;
      prod = (int'(c) - int'(ChromaMid)) * k;
      return prod >>> 8;
    endfunction

    function int clamp8(int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    function pixel_t rgb555_of(sample_t y, int du, int dv);
      int r, b, g, y_term, rb_term;
      logic [7:0] r8, g8, b8;
      r       = clamp8(int'(y) + dv);
      b       = clamp8(int'(y) + du);
      y_term  = (int'(y) * int'(CoefYG)) >>> 7;
      rb_term = (r * int'(CoefRG) + b * int'(CoefBG)) >>> 7;
      g       = clamp8(int'(y) + y_term - rb_term);
      r8 = r[7:0];
      g8 = g[7:0];
      b8 = b[7:0];
      return {r8[7:3], g8[7:3], b8[7:3]};
    endfunction

    // Accepted input item: work out the pair it must produce
    function void note_input(logic [InDataW-1:0] d);
      pixel_pair_t exp_pair;
      int du, dv;
      du = chroma_shift(d[23:16], int'(CoefU));
      dv = chroma_shift(d[31:24], int'(CoefV));
      exp_pair.pad    = '0;
      exp_pair.first  = rgb555_of(d[7:0], du, dv);
      exp_pair.second = rgb555_of(d[15:8], du, dv);
      pair_q.push_back(exp_pair);
    endfunction

    // Accepted result item: compare field by field with the oldest pair
    function void check_result(logic [OutDataW-1:0] d);
      pixel_pair_t exp_pair, got;
      got = d;
      if (pair_q.size() == 0) begin
        $display("%0t: unexpected result item: expected none actual %h", $time, d);
        errors++;
        return;
      end
      exp_pair = pair_q.pop_front();
      if (got.first !== exp_pair.first) begin
        $display("%0t: pixel_first mismatch: expected %h actual %h",
                 $time, exp_pair.first, got.first);
        errors++;
      end
      if (got.second !== exp_pair.second) begin
        $display("%0t: pixel_second mismatch: expected %h actual %h",
                 $time, exp_pair.second, got.second);
        errors++;
      end
      if (got.pad !== exp_pair.pad) begin
        $display("%0t: padding bits mismatch: expected %h actual %h",
                 $time, exp_pair.pad, got.pad);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pair_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;

  pair_scoreboard sb = new();
  int unsigned    src_idle_pct  = 0;
  int unsigned    snk_stall_pct = 0;
  int unsigned    quiet_cycles  = 0;

  yuv_pair_to_rgb555_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready)
  );

  // Clock and input values from time zero
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b1;
  end

  always #2 clk_i = ~clk_i;

  // Result side: check accepted items, then choose next tready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog: give up when no item moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one input item, with random idle cycles ahead of it
  task automatic push_pair(input sample_t y0, input sample_t y1,
                           input sample_t u, input sample_t v);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tdata  <= {v, u, y1, y0};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input({v, u, y1, y0});
  endtask

  // Mostly uniform samples, with the range ends and the midpoint weighted up
  function automatic sample_t pick_sample();
    sample_t s;
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(5))
        0:       s = 8'd0;
        1:       s = 8'd1;
        2:       s = 8'd127;
        3:       s = 8'd128;
        4:       s = 8'd254;
        default: s = 8'd255;
      endcase
    end else begin
      s = sample_t'($urandom_range(255));
    end
    return s;
  endfunction

  task automatic push_random(input int unsigned count);
    repeat (count) push_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endtask

  // Hold the sender off until the pipe has emptied
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range ends, clip on both sides, neutral chroma, bit patterns
    push_pair(8'd0,   8'd0,   8'd0,   8'd0);
    push_pair(8'd255, 8'd255, 8'd255, 8'd255);
    push_pair(8'd0,   8'd255, 8'd128, 8'd128);
    push_pair(8'd255, 8'd0,   8'd128, 8'd128);
    push_pair(8'd128, 8'd128, 8'd0,   8'd0);
    push_pair(8'd128, 8'd128, 8'd255, 8'd255);
    push_pair(8'd128, 8'd128, 8'd0,   8'd255);
    push_pair(8'd128, 8'd128, 8'd255, 8'd0);
    push_pair(8'd0,   8'd0,   8'd255, 8'd255);
    push_pair(8'd255, 8'd255, 8'd0,   8'd0);
    push_pair(8'd16,  8'd235, 8'd16,  8'd240);
    push_pair(8'd235, 8'd16,  8'd240, 8'd16);
    push_pair(8'd1,   8'd254, 8'd127, 8'd129);
    push_pair(8'd254, 8'd1,   8'd129, 8'd127);
    push_pair(8'd0,   8'd255, 8'd0,   8'd255);
    push_pair(8'd255, 8'd0,   8'd255, 8'd0);
    push_pair(8'd128, 8'd127, 8'd127, 8'd128);
    push_pair(8'hAA,  8'h55,  8'hAA,  8'h55);
    push_pair(8'h55,  8'hAA,  8'h55,  8'hAA);
    push_pair(8'd81,  8'd145, 8'd90,  8'd240);
    drain_pipe();

    // Random phases: free flow, idle sender, stalling receiver, both
    push_random(PhaseItems);
    drain_pipe();
    src_idle_pct  = 65;
    snk_stall_pct = 0;
    push_random(PhaseItems);
    drain_pipe();
    src_idle_pct  = 0;
    snk_stall_pct = 65;
    push_random(PhaseItems);
    drain_pipe();
    src_idle_pct  = 13;
    snk_stall_pct = 13;
    push_random(PhaseItems);
    drain_pipe();

    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/yp2rgb_pkg.sv
rtl/core/yuv_pair_to_rgb555_core.sv
rtl/core/yp2rgb_checker.sv
tb/tb_top.sv
